@@ src/scancode_set1_to_ascii_core_assert.svh @@
// Assertion macros shared by the translator RTL.
`ifndef SCANCODE_SET1_TO_ASCII_CORE_ASSERT_SVH
`define SCANCODE_SET1_TO_ASCII_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SS1A_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SS1A_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ss1a_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ss1a_pkg;

	localparam int unsigned ScanW = 8;
	localparam int unsigned CodeW = 7;
	localparam int unsigned CharW = 7;

	localparam logic [CodeW-1:0] KeyLshift   = 7'h2A;
	localparam logic [CodeW-1:0] KeyRshift   = 7'h36;
	localparam logic [CodeW-1:0] KeyCapslock = 7'h3A;
	localparam int unsigned      BreakBit    = 7;
	localparam int unsigned      CaseBit     = 5;

	localparam logic [CharW-1:0] ChLowerA = 7'h61;
	localparam logic [CharW-1:0] ChLowerZ = 7'h7A;
	localparam logic [CharW-1:0] ChUpperA = 7'h41;
	localparam logic [CharW-1:0] ChUpperZ = 7'h5A;

	typedef struct packed {
		logic shift;
		logic caps;
	} flags_t;

	function automatic logic [CharW-1:0] plain_map(input logic [CodeW-1:0] code);
		logic [CharW-1:0] ch;
		case (code)
			7'h01: ch = 7'h1B;
			7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;
			7'h05: ch = 7'h34;  7'h06: ch = 7'h35;  7'h07: ch = 7'h36;
			7'h08: ch = 7'h37;  7'h09: ch = 7'h38;  7'h0A: ch = 7'h39;
			7'h0B: ch = 7'h30;  7'h0C: ch = 7'h2D;  7'h0D: ch = 7'h3D;
			7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;
			7'h10: ch = 7'h71;  7'h11: ch = 7'h77;  7'h12: ch = 7'h65;
			7'h13: ch = 7'h72;  7'h14: ch = 7'h74;  7'h15: ch = 7'h79;
			7'h16: ch = 7'h75;  7'h17: ch = 7'h69;  7'h18: ch = 7'h6F;
			7'h19: ch = 7'h70;  7'h1A: ch = 7'h5B;  7'h1B: ch = 7'h5D;
			7'h1C: ch = 7'h0A;
			7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;  7'h20: ch = 7'h64;
			7'h21: ch = 7'h66;  7'h22: ch = 7'h67;  7'h23: ch = 7'h68;
			7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;  7'h26: ch = 7'h6C;
			7'h27: ch = 7'h3B;  7'h28: ch = 7'h27;  7'h29: ch = 7'h60;
			7'h2B: ch = 7'h5C;
			7'h2C: ch = 7'h7A;  7'h2D: ch = 7'h78;  7'h2E: ch = 7'h63;
			7'h2F: ch = 7'h76;  7'h30: ch = 7'h62;  7'h31: ch = 7'h6E;
			7'h32: ch = 7'h6D;  7'h33: ch = 7'h2C;  7'h34: ch = 7'h2E;
			7'h35: ch = 7'h2F;
			7'h37: ch = 7'h2A;
			7'h39: ch = 7'h20;
			default: ch = '0;
		endcase
		return ch;
	endfunction

	function automatic logic [CharW-1:0] shifted_map(input logic [CodeW-1:0] code);
		logic [CharW-1:0] ch;
		case (code)
			7'h01: ch = 7'h1B;
			7'h02: ch = 7'h21;  7'h03: ch = 7'h40;  7'h04: ch = 7'h23;
			7'h05: ch = 7'h24;  7'h06: ch = 7'h25;  7'h07: ch = 7'h5E;
			7'h08: ch = 7'h26;  7'h09: ch = 7'h2A;  7'h0A: ch = 7'h28;
			7'h0B: ch = 7'h29;  7'h0C: ch = 7'h5F;  7'h0D: ch = 7'h2B;
			7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;
			7'h10: ch = 7'h51;  7'h11: ch = 7'h57;  7'h12: ch = 7'h45;
			7'h13: ch = 7'h52;  7'h14: ch = 7'h54;  7'h15: ch = 7'h59;
			7'h16: ch = 7'h55;  7'h17: ch = 7'h49;  7'h18: ch = 7'h4F;
			7'h19: ch = 7'h50;  7'h1A: ch = 7'h7B;  7'h1B: ch = 7'h7D;
			7'h1C: ch = 7'h0A;
			7'h1E: ch = 7'h41;  7'h1F: ch = 7'h53;  7'h20: ch = 7'h44;
			7'h21: ch = 7'h46;  7'h22: ch = 7'h47;  7'h23: ch = 7'h48;
			7'h24: ch = 7'h4A;  7'h25: ch = 7'h4B;  7'h26: ch = 7'h4C;
			7'h27: ch = 7'h3A;  7'h28: ch = 7'h22;  7'h29: ch = 7'h7E;
			7'h2B: ch = 7'h7C;
			7'h2C: ch = 7'h5A;  7'h2D: ch = 7'h58;  7'h2E: ch = 7'h43;
			7'h2F: ch = 7'h56;  7'h30: ch = 7'h42;  7'h31: ch = 7'h4E;
			7'h32: ch = 7'h4D;  7'h33: ch = 7'h3C;  7'h34: ch = 7'h3E;
			7'h35: ch = 7'h3F;
			7'h37: ch = 7'h2A;
			7'h39: ch = 7'h20;
			default: ch = '0;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

@@ src/ss1a_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ss1a_in_if import ss1a_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ScanW-1:0] scan_byte;
	logic             from_aux;

	modport source (output valid, output scan_byte, output from_aux, input ready);
	modport sink (input valid, input scan_byte, input from_aux, output ready);
endinterface

interface ss1a_out_if import ss1a_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] character;
	logic             shift_held;
	logic             caps_on;

	modport source (output valid, output character, output shift_held, output caps_on,
		input ready);
	modport sink (input valid, input character, input shift_held, input caps_on,
		output ready);
endinterface

interface ss1a_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/ss1a_xlate.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ss1a_xlate import ss1a_pkg::*; (
	input  logic [ScanW-1:0] scan_byte,
	input  logic             from_aux,
	input  logic             enable,
	input  flags_t           cur,
	output logic [CharW-1:0] character,
	output flags_t           nxt
);

	logic [CodeW-1:0] code;
	logic             is_break;
	logic             is_shift;
	logic [CharW-1:0] looked_up;

	assign code     = scan_byte[CodeW-1:0];
	assign is_break = scan_byte[BreakBit];
	assign is_shift = (code == KeyLshift) || (code == KeyRshift);

	always_comb begin
		looked_up = cur.shift ? shifted_map(code) : plain_map(code);
		// Caps lock flips letter case against whatever shift selected.
		if (cur.caps) begin
			if (!cur.shift && looked_up >= ChLowerA && looked_up <= ChLowerZ) begin
				looked_up[CaseBit] = 1'b0;
			end else if (cur.shift && looked_up >= ChUpperA && looked_up <= ChUpperZ) begin
				looked_up[CaseBit] = 1'b1;
			end
		end
	end

	always_comb begin
		nxt       = cur;
		character = '0;
		if (enable && !from_aux) begin
			if (is_break) begin
				if (is_shift) begin
					nxt.shift = 1'b0;
				end
			end else if (is_shift) begin
				nxt.shift = 1'b1;
			end else if (code == KeyCapslock) begin
				nxt.caps = ~cur.caps;
			end else begin
				character = looked_up;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/scancode_set1_to_ascii_core.sv @@
// Channel   Dir  Payload                              Transfer when
// cfg       in   data (enable)                        valid & ready (ready tied high)
// keys      in   scan_byte[7:0], from_aux             valid & ready
// chars     out  character[6:0], shift_held, caps_on  valid & ready
//
// Each byte waits in the input register and is translated on its way
// into the result register, so a byte transfers in every cycle unless the result is stalled.
// The table lookup and flag update sit between those two registers.
// A stalled result holds the input register; keys.ready drops only while both are full.
// Reset clears enable, shift and caps lock, and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

`include "scancode_set1_to_ascii_core_assert.svh"

module scancode_set1_to_ascii_core import ss1a_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ss1a_cfg_if.sink     cfg,
	ss1a_in_if.sink      keys,
	ss1a_out_if.source   chars
);

	logic             enable_q;
	flags_t           flags_q;
	flags_t           flags_nxt;

	logic             valid_s1;
	logic [ScanW-1:0] byte_s1;
	logic             aux_s1;

	logic             valid_s2;
	logic [CharW-1:0] char_s2;
	flags_t           flags_s2;

	logic [CharW-1:0] char_nxt;
	logic             advance;

	assign advance    = valid_s1 && (!valid_s2 || chars.ready);
	assign keys.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	ss1a_xlate u_xlate (
		.scan_byte (byte_s1),
		.from_aux  (aux_s1),
		.enable    (enable_q),
		.cur       (flags_q),
		.character (char_nxt),
		.nxt       (flags_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			flags_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg.valid) begin
				enable_q <= cfg.data;
			end
			if (keys.ready) begin
				valid_s1 <= keys.valid;
			end
			if (advance) begin
				flags_q  <= flags_nxt;
				valid_s2 <= 1'b1;
			end else if (chars.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			byte_s1 <= keys.scan_byte;
			aux_s1  <= keys.from_aux;
		end
		if (advance) begin
			char_s2  <= char_nxt;
			flags_s2 <= flags_nxt;
		end
	end

	assign chars.valid      = valid_s2;
	assign chars.character  = char_s2;
	assign chars.shift_held = flags_s2.shift;
	assign chars.caps_on    = flags_s2.caps;

	`SS1A_ASSERT_NEXT(a_adv_gives_result, clk, arst_n, advance, valid_s2,
		"translated byte did not reach the result register")
	`SS1A_ASSERT_NEXT(a_disabled_no_char, clk, arst_n, advance && !enable_q,
		char_s2 == '0 && flags_s2 == flags_q, "disabled translator produced output")
	`SS1A_ASSERT_NEXT(a_flags_hold, clk, arst_n, !advance, flags_q == $past(flags_q),
		"modifier flags changed without a byte")
	`SS1A_ASSERT_NOW(a_result_flags, clk, arst_n, valid_s2, flags_s2 == flags_q,
		"reported flags differ from the live flags")

endmodule

`default_nettype wire
